>>> rtl/cals_pkg.sv
// ----------------------------------------------------------------------------
// cals_pkg: shared types and constants for the comment-aware line matcher
// Item and result structs, op codes passed from classifier to matcher,
// register indexes and the character codes the comment scanner looks for.
// ----------------------------------------------------------------------------
package cals_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int PAT_LEN_W   = 6;     // holds 0..MAX_PATTERN
    localparam int CFG_IDX_W   = 3;
    localparam int OPQ_DEPTH   = 4;
    localparam int OPQ_AW      = 2;

    // item modes
    localparam logic [1:0] MODE_TEXT = 2'd0;
    localparam logic [1:0] MODE_EOL  = 2'd1;
    localparam logic [1:0] MODE_SOF  = 2'd2;

    // op kinds, front to back
    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_EOL  = 2'd1;
    localparam logic [1:0] OP_SOF  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAT0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAT3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AWARE = 3'd5;

    // characters
    localparam logic [7:0] CH_DQUOTE  = 8'd34;
    localparam logic [7:0] CH_SQUOTE  = 8'd39;
    localparam logic [7:0] CH_SLASH   = 8'd47;
    localparam logic [7:0] CH_STAR    = 8'd42;
    localparam logic [7:0] LEAD_LIMIT = 8'h80;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] text_byte;
    } t_in_item;

    typedef struct packed {
        logic line_match;
        logic file_match;
    } t_out_item;

    // up to two code bytes, oldest in b0
    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] cnt;
        logic [7:0] b0;
        logic [7:0] b1;
    } t_op;

    // pattern aligned to the window: apat[j] is compared with window entry j
    typedef struct packed {
        logic [MAX_PATTERN-1:0][7:0] apat;
        logic [MAX_PATTERN-1:0]      mask;
        logic [PAT_LEN_W-1:0]        len;
    } t_match_cfg;

endpackage

>>> rtl/comment_aware_line_matcher.sv
// ----------------------------------------------------------------------------
// comment_aware_line_matcher: pattern search on the code part of C lines
// Strips C comments (when aware) from a byte stream and reports, at each
// line end, whether the line's remaining code held the configured pattern.
// ----------------------------------------------------------------------------
// Bytes, line ends and file starts are pushed one transaction per cycle; the
// block accepts one input transaction every cycle for as long as its output
// queue is drained. The comment scanner classifies a transaction in the cycle
// it is pushed and hands at most two code bytes to a four-deep op queue; the
// window matcher takes one op per cycle, holding a line-end op while the
// result buffer is full, and shifts both bytes into a 32-byte line window,
// checking the aligned pattern after each with 32 byte comparators per byte.
// A line-end result waits in the op queue and is then registered into the
// result buffer; the two-entry result buffer lets input keep flowing while
// a result waits to be popped. Only line ends give a result; a file start
// clears the scanner and line state, file match included. Pattern registers
// may be rewritten whenever no transaction is in flight, mid-line too; the
// pattern is realigned to the window in a register on every write, so matching
// always uses the current pattern. A length of zero matches every line, a
// length above 32 is taken as 32. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module comment_aware_line_matcher
    import cals_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input queue side
    input  logic                 push,
    output logic                 full,
    input  t_in_item             i_in_item,
    // result queue side
    output logic                 empty,
    input  logic                 pop,
    output t_out_item            o_out_item,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data
);

    // configuration registers
    logic [3:0][63:0]     r_pw, n_pw;
    logic [PAT_LEN_W-1:0] r_len, n_len;
    logic                 r_aware, n_aware;
    t_match_cfg           r_mcfg, n_mcfg;

    logic                 accept;
    logic                 fr_valid;
    t_op                  fr_op;
    logic                 q_full, q_valid, q_rd;
    t_op                  q_op;

    // register write decode
    always_comb begin
        n_pw    = r_pw;
        n_len   = r_len;
        n_aware = r_aware;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PAT0:  n_pw[0] = i_cfg_data;
                REG_PAT1:  n_pw[1] = i_cfg_data;
                REG_PAT2:  n_pw[2] = i_cfg_data;
                REG_PAT3:  n_pw[3] = i_cfg_data;
                REG_LEN:   n_len   = i_cfg_data[PAT_LEN_W-1:0];
                REG_AWARE: n_aware = i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // realign the pattern so that window entry j (newest first) meets
    // pattern byte len-1-j; entries at or beyond the length are masked off
    always_comb begin
        logic [MAX_PATTERN-1:0][7:0] v_bytes;
        logic [PAT_LEN_W-1:0]        v_eff;
        logic [PAT_LEN_W-1:0]        k;
        v_bytes = n_pw;
        v_eff   = (n_len > PAT_LEN_W'(MAX_PATTERN)) ? PAT_LEN_W'(MAX_PATTERN) : n_len;
        k       = '0;
        n_mcfg  = '0;
        n_mcfg.len = v_eff;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            if (PAT_LEN_W'(j) < v_eff) begin
                k = v_eff - PAT_LEN_W'(j) - 1'b1;
                n_mcfg.apat[j] = v_bytes[k[PAT_LEN_W-2:0]];
                n_mcfg.mask[j] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw        <= '0;
            r_len       <= PAT_LEN_W'(1);
            r_aware     <= 1'b1;
            // aligned form of the reset pattern: one zero byte
            r_mcfg      <= '{apat: '0, mask: MAX_PATTERN'(1), len: PAT_LEN_W'(1)};
        end else begin
            r_pw    <= n_pw;
            r_len   <= n_len;
            r_aware <= n_aware;
            r_mcfg  <= n_mcfg;
        end
    end

    assign full   = q_full;
    assign accept = push && !q_full;

    cals_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_in_item),
        .i_aware    (r_aware),
        .o_op_valid (fr_valid),
        .o_op       (fr_op)
    );

    cals_opq u_opq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fr_valid),
        .i_wdata (fr_op),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_rdata (q_op),
        .i_rd    (q_rd)
    );

    logic back_ready;

    assign q_rd = q_valid && back_ready;

    cals_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (q_valid),
        .i_op       (q_op),
        .o_op_ready (back_ready),
        .i_mcfg     (r_mcfg),
        .o_empty    (empty),
        .o_out      (o_out_item),
        .i_pop      (pop)
    );

endmodule

>>> rtl/cals_front.sv
// ----------------------------------------------------------------------------
// cals_front: comment scanner
// Classifies each accepted item in the same cycle; an item with code bytes to
// keep, a line end or a file start becomes an op carrying its code bytes.
// ----------------------------------------------------------------------------
module cals_front
    import cals_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    input  logic     i_aware,
    output logic     o_op_valid,
    output t_op      o_op
);

    typedef struct packed {
        logic dq_t;
        logic sq_t;
        logic slash;
        logic star;
        logic follow;
        logic keep;
    } t_fresh;

    // plain byte outside any pending mark
    function automatic t_fresh f_fresh(input logic [7:0] b, input logic blk);
        t_fresh f;
        f = '0;
        if (b == CH_DQUOTE) begin
            f.dq_t = 1'b1;
            f.keep = !blk;
        end else if (b == CH_SQUOTE) begin
            f.sq_t = 1'b1;
            f.keep = !blk;
        end else if (b == CH_SLASH) begin
            f.slash = 1'b1;
        end else if (b == CH_STAR) begin
            if (blk) begin
                f.star = 1'b1;
            end else begin
                f.keep = 1'b1;
            end
        end else begin
            f.keep   = !blk;
            f.follow = (b > LEAD_LIMIT);
        end
        return f;
    endfunction

    logic r_blk, r_dq, r_sq, r_lc, r_rod, r_slash, r_star, r_fol;
    logic n_blk, n_dq, n_sq, n_lc, n_rod, n_slash, n_star, n_fol;
    logic [7:0] b;
    logic   quiet;
    t_fresh f;
    t_op    v_op;
    logic   v_valid;

    assign b     = i_item.text_byte;
    assign quiet = !r_dq && !r_sq;

    always_comb begin
        n_blk   = r_blk;
        n_dq    = r_dq;
        n_sq    = r_sq;
        n_lc    = r_lc;
        n_rod   = r_rod;
        n_slash = r_slash;
        n_star  = r_star;
        n_fol   = r_fol;
        f       = '0;
        v_op    = '0;
        v_op.kind = OP_PUSH;
        v_valid = 1'b0;
        if (i_accept) begin
            case (i_item.mode)
                MODE_TEXT: begin
                    if (!i_aware) begin
                        v_op.cnt = 2'd1;
                        v_op.b0  = b;
                    end else if (r_lc) begin
                        // rest of line is comment; only watch for a block close
                        if (!r_rod) begin
                            if (r_blk) begin
                                if (r_star && b == CH_SLASH) begin
                                    n_blk  = 1'b0;
                                    n_rod  = 1'b1;
                                    n_star = 1'b0;
                                end else begin
                                    n_star = (b == CH_STAR);
                                end
                            end else begin
                                n_star = 1'b0;
                            end
                        end
                    end else if (r_fol) begin
                        n_fol = 1'b0;
                        if (!r_blk) begin
                            v_op.cnt = 2'd1;
                            v_op.b0  = b;
                        end
                    end else if (r_slash) begin
                        n_slash = 1'b0;
                        if (b == CH_SLASH && quiet) begin
                            n_lc   = 1'b1;
                            n_star = 1'b0;
                        end else if (b == CH_STAR && quiet) begin
                            n_blk = 1'b1;
                            f     = f_fresh(b, 1'b1);
                        end else begin
                            // held slash opened no comment; it is code unless inside a block
                            if (!r_blk) begin
                                v_op.cnt = 2'd1;
                                v_op.b0  = CH_SLASH;
                            end
                            f = f_fresh(b, r_blk);
                        end
                    end else if (r_star && b == CH_SLASH) begin
                        n_star = 1'b0;
                        n_blk  = 1'b0;
                    end else begin
                        n_star = 1'b0;
                        f      = f_fresh(b, r_blk);
                    end
                    n_dq = n_dq ^ f.dq_t;
                    n_sq = n_sq ^ f.sq_t;
                    if (f.slash) begin
                        n_slash = 1'b1;
                    end
                    if (f.star) begin
                        n_star = 1'b1;
                    end
                    if (f.follow) begin
                        n_fol = 1'b1;
                    end
                    if (f.keep) begin
                        if (v_op.cnt == 2'd0) begin
                            v_op.cnt = 2'd1;
                            v_op.b0  = b;
                        end else begin
                            v_op.cnt = 2'd2;
                            v_op.b1  = b;
                        end
                    end
                    v_valid = (v_op.cnt != 2'd0);
                end
                MODE_EOL: begin
                    if (r_slash && !r_blk) begin
                        v_op.cnt = 2'd1;
                        v_op.b0  = CH_SLASH;
                    end
                    v_op.kind = OP_EOL;
                    v_valid   = 1'b1;
                    n_dq = 1'b0; n_sq = 1'b0; n_lc = 1'b0; n_rod = 1'b0;
                    n_slash = 1'b0; n_star = 1'b0; n_fol = 1'b0;
                end
                MODE_SOF: begin
                    v_op.kind = OP_SOF;
                    v_valid   = 1'b1;
                    n_blk = 1'b0;
                    n_dq = 1'b0; n_sq = 1'b0; n_lc = 1'b0; n_rod = 1'b0;
                    n_slash = 1'b0; n_star = 1'b0; n_fol = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk   <= 1'b0;
            r_dq    <= 1'b0;
            r_sq    <= 1'b0;
            r_lc    <= 1'b0;
            r_rod   <= 1'b0;
            r_slash <= 1'b0;
            r_star  <= 1'b0;
            r_fol   <= 1'b0;
        end else begin
            r_blk   <= n_blk;
            r_dq    <= n_dq;
            r_sq    <= n_sq;
            r_lc    <= n_lc;
            r_rod   <= n_rod;
            r_slash <= n_slash;
            r_star  <= n_star;
            r_fol   <= n_fol;
        end
    end

    assign o_op_valid = v_valid;
    assign o_op       = v_op;

endmodule

>>> rtl/cals_opq.sv
// ----------------------------------------------------------------------------
// cals_opq: op queue
// Short FIFO between the comment scanner and the window matcher.
// ----------------------------------------------------------------------------
module cals_opq
    import cals_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_op  i_wdata,
    output logic o_full,
    output logic o_valid,
    output t_op  o_rdata,
    input  logic i_rd
);

    t_op               r_mem [OPQ_DEPTH];
    logic [OPQ_AW-1:0] r_wp, r_rp;
    logic [OPQ_AW:0]   r_count;
    logic              wr_en, rd_en;

    assign o_full  = (r_count == (OPQ_AW+1)'(OPQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && o_valid;
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd_en) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/cals_back.sv
// ----------------------------------------------------------------------------
// cals_back: window matcher
// Shifts kept code bytes into the line window, compares the aligned pattern
// after each byte and queues a result at every line end.
// ----------------------------------------------------------------------------
module cals_back
    import cals_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_op_valid,
    input  t_op        i_op,
    output logic       o_op_ready,
    input  t_match_cfg i_mcfg,
    output logic       o_empty,
    output t_out_item  o_out,
    input  logic       i_pop
);

    function automatic logic [PAT_LEN_W-1:0] f_sat(input logic [PAT_LEN_W-1:0] v);
        return (v == PAT_LEN_W'(MAX_PATTERN)) ? v : v + 1'b1;
    endfunction

    function automatic logic f_hit(input logic [MAX_PATTERN-1:0][7:0] win,
                                   input logic [PAT_LEN_W-1:0] fill,
                                   input t_match_cfg c);
        logic ok;
        ok = (c.len != '0) && (fill >= c.len);
        for (int j = 0; j < MAX_PATTERN; j++) begin
            if (c.mask[j] && (win[j] != c.apat[j])) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    logic [MAX_PATTERN-1:0][7:0] r_win, n_win, win1, win2;
    logic [PAT_LEN_W-1:0]        r_fill, n_fill, fill1, fill2;
    logic                        r_line, n_line, r_file, n_file;
    logic                        take, hit, v_line;

    // two-entry result buffer
    t_out_item   r_res [2];
    logic        r_rwp, r_rrp;
    logic [1:0]  r_rcnt;
    logic        res_wr, res_rd;
    t_out_item   res_data;

    assign o_op_ready = (i_op.kind != OP_EOL) || (r_rcnt != 2'd2);
    assign take       = i_op_valid && o_op_ready;

    assign win1  = {r_win[MAX_PATTERN-2:0], i_op.b0};
    assign win2  = {win1[MAX_PATTERN-2:0], i_op.b1};
    assign fill1 = f_sat(r_fill);
    assign fill2 = f_sat(fill1);

    always_comb begin
        n_win    = r_win;
        n_fill   = r_fill;
        n_line   = r_line;
        n_file   = r_file;
        hit      = 1'b0;
        v_line   = 1'b0;
        res_wr   = 1'b0;
        res_data = '0;
        if (take) begin
            case (i_op.cnt)
                2'd1: begin
                    n_win  = win1;
                    n_fill = fill1;
                    hit    = f_hit(win1, fill1, i_mcfg);
                end
                2'd2: begin
                    n_win  = win2;
                    n_fill = fill2;
                    hit    = f_hit(win1, fill1, i_mcfg) || f_hit(win2, fill2, i_mcfg);
                end
                default: begin
                end
            endcase
            n_line = r_line || hit;
            case (i_op.kind)
                OP_EOL: begin
                    // empty pattern is found on every line
                    v_line = n_line || (i_mcfg.len == '0);
                    res_wr = 1'b1;
                    res_data.line_match = v_line;
                    res_data.file_match = r_file || v_line;
                    n_file = r_file || v_line;
                    n_fill = '0;
                    n_line = 1'b0;
                end
                OP_SOF: begin
                    n_fill = '0;
                    n_line = 1'b0;
                    n_file = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    assign res_rd  = i_pop && (r_rcnt != 2'd0);
    assign o_empty = (r_rcnt == 2'd0);
    assign o_out   = r_res[r_rrp];

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        if (res_wr) begin
            r_res[r_rwp] <= res_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_line <= 1'b0;
            r_file <= 1'b0;
            r_rwp  <= 1'b0;
            r_rrp  <= 1'b0;
            r_rcnt <= 2'd0;
        end else begin
            r_fill <= n_fill;
            r_line <= n_line;
            r_file <= n_file;
            if (res_wr) begin
                r_rwp <= ~r_rwp;
            end
            if (res_rd) begin
                r_rrp <= ~r_rrp;
            end
            case ({res_wr, res_rd})
                2'b10:   r_rcnt <= r_rcnt + 2'd1;
                2'b01:   r_rcnt <= r_rcnt - 2'd1;
                default: r_rcnt <= r_rcnt;
            endcase
        end
    end

    a_rcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rcnt <= 2'd2)
        else $error("result buffer overfilled");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= PAT_LEN_W'(MAX_PATTERN))
        else $error("window fill out of range");

    a_eol_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_op.kind == OP_EOL) |=> (r_fill == '0 && !r_line))
        else $error("line state not cleared after line end");

    a_sof_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_op.kind == OP_SOF) |=> (!r_file && !r_line && r_fill == '0))
        else $error("file state not cleared after file start");

endmodule
